// File: hw/rtl/srds_pkg.sv
// Shared types and constants for the signed radix to digit symbols unit.
package srds_pkg;

   // Largest radix that is converted; the alphabet holds this many entries
   localparam int MaxRadix   = 16;
   localparam int DigitW     = 4;
   localparam int MagW       = 32;
   localparam int MaxDigits  = 32;
   localparam int StackIdxW  = 5;
   localparam int StackCntW  = 6;
   localparam int RadixW     = 5;
   localparam int CsrDataW   = 64;
   localparam int CsrIdxW    = 2;

   // Register indexes on the configuration port
   localparam logic [CsrIdxW-1:0] CSR_DIGITS_LOW  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_DIGITS_HIGH = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_RADIX       = 2'd2;

   // Reserved character codes
   localparam logic [7:0] SYM_PLUS  = 8'd43;
   localparam logic [7:0] SYM_MINUS = 8'd45;
   localparam logic [7:0] SYM_NUL   = 8'd0;

   typedef logic [7:0] sym_type;
   typedef sym_type [MaxRadix-1:0] alpha_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // Alphabet checker status
   typedef struct packed {
      logic done;
      logic ok;
   } chk_stat_type;

   // Divider control and status
   typedef struct packed {
      logic load;
      logic run;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic              zero;
      logic [DigitW-1:0] digit;
   } div_stat_type;

endpackage

// File: hw/rtl/srds_alpha_chk.sv
// Alphabet checker: one entry per cycle against reserved codes and later entries.
module srds_alpha_chk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  srds_pkg::alpha_type           alpha,
   input  logic [srds_pkg::RadixW-1:0]   radix,
   output srds_pkg::chk_stat_type        status
);
   import srds_pkg::*;

   logic              busy_ff, busy_in;
   logic [DigitW-1:0] idx_ff, idx_in;
   logic              bad_ff, bad_in;
   sym_type           cur;
   logic              bad_now;
   logic              last_idx;

   // Test the current entry; the duplicate search covers later used entries only
   always_comb begin
      cur     = alpha[idx_ff];
      bad_now = (cur == SYM_NUL) || (cur == SYM_PLUS) || (cur == SYM_MINUS);
      for (int j = 0; j < MaxRadix; j++) begin
         if ((DigitW'(j) > idx_ff) && (RadixW'(j) < radix) && (alpha[j] == cur)) begin
            bad_now = 1'b1;
         end
      end
      last_idx = ({1'b0, idx_ff} == (radix - RadixW'(1)));
   end

   // Sweep sequencing
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      bad_in  = bad_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         bad_in  = 1'b0;
      end else if (busy_ff) begin
         bad_in = bad_ff | bad_now;
         idx_in = idx_ff + DigitW'(1);
         if (last_idx) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         bad_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         bad_ff  <= bad_in;
      end
   end

   assign status.done = busy_ff && last_idx;
   assign status.ok   = !(bad_ff || bad_now);

endmodule

// File: hw/rtl/srds_div.sv
// Bit-serial restoring divider by the radix: one quotient bit per cycle.
module srds_div (
   input  logic                          clock,
   input  logic                          reset,
   input  srds_pkg::div_cmd_type         cmd,
   input  logic [srds_pkg::MagW-1:0]     dividend,
   input  logic [srds_pkg::RadixW-1:0]   radix,
   output srds_pkg::div_stat_type        status
);
   import srds_pkg::*;

   logic              busy_ff, busy_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [MagW-1:0]   quo_ff, quo_in;
   logic [DigitW-1:0] rem_ff, rem_in;
   logic [RadixW-1:0] trial;
   logic              ge;
   logic [MagW-1:0]   quo_step;
   logic [DigitW-1:0] rem_step;

   // One restoring step: remainder stays below the radix, so it fits a digit
   always_comb begin
      trial    = {rem_ff, quo_ff[MagW-1]};
      ge       = (trial >= radix);
      rem_step = ge ? DigitW'(trial - radix) : DigitW'(trial);
      quo_step = {quo_ff[MagW-2:0], ge};
   end

   // A run issued on the finishing step keeps that step's quotient
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (cmd.load) begin
         quo_in = dividend;
      end else begin
         if (busy_ff) begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_in = 1'b0;
            end
         end
         if (cmd.run) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            rem_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   // Digit and quotient are final on the step that finishes the word
   assign status.done  = busy_ff && (cnt_ff == 5'd31);
   assign status.digit = rem_step;
   assign status.zero  = (quo_step == '0);

endmodule

// File: hw/rtl/signed_radix_to_digit_symbols_unit.sv
// Top level: signed value to radix digit symbols, one item at a time.
//
// Input channel req_*: one signed 32-bit value per item, taken when req_valid
// is high and req_stall is low. req_stall is high while an item is in work.
// Result channel rsp_*: one character code per transfer, rsp_last on the final
// symbol of a run; a minus sign leads a negative value.
// Configuration csr_*: digits_low, digits_high and radix, to be written only
// while idle; the user is bound to this, the block does no check of its own.
// A radix below 2 or above 16, or a bad alphabet, yields no results.
// Steps per item: accept, alphabet check (one entry per cycle), then the
// bit-serial divider pushes the digits onto a stack, least significant
// first, then the minus sign for a negative value and the popped digits.
// rsp_stall holds the output register and pauses the emit steps; the next
// item is accepted while the final symbol still waits in that register.
// Reset (synchronous, active high) clears the control and configuration
// registers to 0 and drops any item in work; the digit stack and the data
// registers are left as they were.
module signed_radix_to_digit_symbols_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [31:0]              req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_symbol,
   output logic                            rsp_last,
   input  logic                            csr_write,
   input  logic [srds_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [srds_pkg::CsrDataW-1:0]   csr_data
);
   import srds_pkg::*;

   logic [CsrDataW-1:0]  dig_lo_ff, dig_hi_ff;
   logic [RadixW-1:0]    radix_ff;
   alpha_type            alpha;
   state_type            state_ff, state_in;
   logic                 neg_ff, neg_in;
   logic [DigitW-1:0]    stack_ff [MaxDigits];
   logic [StackCntW-1:0] count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sym_type              rsp_symbol_ff, rsp_symbol_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 req_fire;
   logic                 radix_ok;
   logic [MagW-1:0]      mag;
   logic                 chk_start;
   chk_stat_type         chk_stat;
   div_cmd_type          div_cmd;
   div_stat_type         div_stat;
   logic                 push;
   logic                 out_free;
   logic [StackIdxW-1:0] top_idx;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dig_lo_ff <= '0;
         dig_hi_ff <= '0;
         radix_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DIGITS_LOW:  dig_lo_ff <= csr_data;
            CSR_DIGITS_HIGH: dig_hi_ff <= csr_data;
            CSR_RADIX:       radix_ff  <= csr_data[RadixW-1:0];
            default: ;
         endcase
      end
   end

   assign alpha    = {dig_hi_ff, dig_lo_ff};
   assign radix_ok = (radix_ff >= RadixW'(2)) && (radix_ff <= RadixW'(MaxRadix));

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign mag       = req_value[31] ? (~req_value + 32'd1) : req_value;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign top_idx  = StackIdxW'(count_ff - StackCntW'(1));

   srds_alpha_chk u_chk (
      .clock  (clock),
      .reset  (reset),
      .start  (chk_start),
      .alpha  (alpha),
      .radix  (radix_ff),
      .status (chk_stat)
   );

   srds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (mag),
      .radix    (radix_ff),
      .status   (div_stat)
   );

   // Sequencer: check, divide digit by digit, then emit sign and digits
   always_comb begin
      state_in      = state_ff;
      neg_in        = neg_ff;
      count_in      = count_ff;
      chk_start     = 1'b0;
      div_cmd       = '0;
      push          = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               neg_in       = req_value[31];
               count_in     = '0;
               div_cmd.load = 1'b1;
               if (radix_ok) begin
                  chk_start = 1'b1;
                  state_in  = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (chk_stat.done) begin
               if (chk_stat.ok) begin
                  div_cmd.run = 1'b1;
                  state_in    = ST_DIVIDE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               push     = 1'b1;
               count_in = count_ff + StackCntW'(1);
               if (!div_stat.zero && (count_ff < StackCntW'(MaxDigits - 1))) begin
                  div_cmd.run = 1'b1;
               end else begin
                  state_in = neg_ff ? ST_SIGN : ST_EMIT;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = SYM_MINUS;
               rsp_last_in   = 1'b0;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = alpha[stack_ff[top_idx]];
               rsp_last_in   = (count_ff == StackCntW'(1));
               count_in      = count_ff - StackCntW'(1);
               if (count_ff == StackCntW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff        <= neg_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Digit stack, filled least significant digit first
   always_ff @(posedge clock) begin
      if (push) begin
         stack_ff[count_ff[StackIdxW-1:0]] <= div_stat.digit;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
